>>> sv/stq_pkg.sv
package stq_pkg;

    localparam int ID_W         = 16;
    localparam int TIME_W       = 32;
    localparam int RESULT_LIMIT = 64;
    localparam int NEXP_W       = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_ADJUST = 2'd1,
        OP_DELETE = 2'd2,
        OP_TICK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_DUP       = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   id;
    } t_entry;

endpackage

>>> sv/stq_ram.sv
module stq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/sorted_timer_queue.sv
// Channel | Handshake                  | Payload
// --------+----------------------------+---------------------------------------------
// in      | i_in_valid / o_in_ready    | i_opcode, i_conn_id, i_time_value
// out     | o_out_valid / i_out_ready  | o_status, o_expired_valid, o_expired_id, o_last
//
// Timers live in one RAM used as a circular buffer in expiry order; the registered read
// splits each walk step into a read state and a check or write state. An add scans for
// duplicates, then shifts later entries up to insert; a delete shifts later entries down;
// adjust runs a delete, then the insert walk of an add; tick pops expired head timers.
// Reset is synchronous and clears count, head and control; no clearing pass over the RAM.
// A stalled output transfer holds the sequencer; o_in_ready is high only when idle.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [ID_W-1:0]   i_conn_id,
    input  logic [TIME_W-1:0] i_time_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_expired_valid,
    output logic [ID_W-1:0]   o_expired_id,
    output logic              o_last
);

    localparam int AW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TIMERS);
    localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(MAX_TIMERS);
    localparam logic [AW-1:0] LAST_ADR = AW'(MAX_TIMERS - 1);
    localparam logic [NEXP_W-1:0] NEXP_MAX = NEXP_W'(RESULT_LIMIT);

    t_state            r_state, n_state;
    t_opcode           r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [TIME_W-1:0] r_time, n_time;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_ipos, n_ipos;
    logic              r_ipos_set, n_ipos_set;
    logic              r_mode_id, n_mode_id;
    logic              r_pend_valid, n_pend_valid;
    logic [ID_W-1:0]   r_pend_id, n_pend_id;
    logic [NEXP_W-1:0] r_nexp, n_nexp;
    t_status           r_status, n_status;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic              r_o_exp_valid, n_o_exp_valid;
    logic [ID_W-1:0]   r_o_exp_id, n_o_exp_id;
    logic              r_o_last, n_o_last;

    logic              w_slot_free;
    logic              w_accept;
    logic [CW-1:0]     w_rd_l, w_wr_l;
    logic              w_wr_en;
    t_entry            w_wr_data, w_rd_data;
    logic [AW-1:0]     w_rd_addr, w_wr_addr;
    logic              w_id_hit, w_later, w_expired;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + {1'b0, l[AW-1:0]};
        if (s >= DEPTH_X) begin
            s = s - DEPTH_X;
        end
        return s[AW-1:0];
    endfunction

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_id_hit    = (w_rd_data.id == r_id);
    assign w_later     = (w_rd_data.expiry > r_time);
    assign w_expired   = !w_later;

    always_comb begin
        unique case (r_state)
            ST_INS_RD:               w_rd_l = r_idx - CW'(1);
            ST_DEL_RD:               w_rd_l = r_idx + CW'(1);
            ST_TICK_RD, ST_TICK_CHK: w_rd_l = '0;
            default:                 w_rd_l = r_idx;
        endcase
    end

    assign w_wr_l    = (r_state == ST_INS_PUT) ? r_ipos : r_idx;
    assign w_rd_addr = f_phys(r_head, w_rd_l);
    assign w_wr_addr = f_phys(r_head, w_wr_l);
    assign w_wr_en   = (r_state == ST_DEL_WR) || (r_state == ST_INS_WR)
                       || (r_state == ST_INS_PUT);
    assign w_wr_data = (r_state == ST_INS_PUT) ? {r_time, r_id} : w_rd_data;

    stq_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(MAX_TIMERS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (t_opcode'(i_opcode) == OP_TICK) ? ST_TICK_RD : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_idx == r_count) begin
                    if (!r_mode_id) begin
                        n_state = ST_INS_RD;
                    end else if (r_op == OP_ADD && r_count != FULL_CNT) begin
                        n_state = ST_INS_RD;
                    end else begin
                        n_state = ST_RESP;
                    end
                end else begin
                    n_state = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (r_mode_id && w_id_hit) begin
                    n_state = (r_op == OP_ADD) ? ST_RESP : ST_DEL_RD;
                end else if (!r_mode_id && w_later) begin
                    n_state = ST_INS_RD;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_DEL_RD: begin
                if (r_idx + CW'(1) == r_count) begin
                    n_state = (r_op == OP_ADJUST) ? ST_SCAN_RD : ST_RESP;
                end else begin
                    n_state = ST_DEL_WR;
                end
            end
            ST_DEL_WR:  n_state = ST_DEL_RD;
            ST_INS_RD:  n_state = (r_idx == r_ipos) ? ST_INS_PUT : ST_INS_WR;
            ST_INS_WR:  n_state = ST_INS_RD;
            ST_INS_PUT: n_state = ST_RESP;
            ST_TICK_RD: begin
                n_state = (r_count != '0 && r_nexp != NEXP_MAX) ? ST_TICK_CHK : ST_RESP;
            end
            ST_TICK_CHK: begin
                if (!w_expired) begin
                    n_state = ST_RESP;
                end else if (!r_pend_valid || w_slot_free) begin
                    n_state = ST_TICK_RD;
                end
            end
            ST_RESP: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and result register
    always_comb begin
        n_op          = r_op;
        n_id          = r_id;
        n_time        = r_time;
        n_head        = r_head;
        n_count       = r_count;
        n_idx         = r_idx;
        n_ipos        = r_ipos;
        n_ipos_set    = r_ipos_set;
        n_mode_id     = r_mode_id;
        n_pend_valid  = r_pend_valid;
        n_pend_id     = r_pend_id;
        n_nexp        = r_nexp;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_o_status    = r_o_status;
        n_o_exp_valid = r_o_exp_valid;
        n_o_exp_id    = r_o_exp_id;
        n_o_last      = r_o_last;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op         = t_opcode'(i_opcode);
                    n_id         = i_conn_id;
                    n_time       = i_time_value;
                    n_idx        = '0;
                    n_ipos_set   = 1'b0;
                    n_mode_id    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_nexp       = '0;
                    n_status     = STAT_OK;
                end
            end
            ST_SCAN_RD: begin
                if (r_idx == r_count) begin
                    if (!r_mode_id) begin
                        n_ipos = r_count;
                    end else if (r_op == OP_ADD) begin
                        if (r_count == FULL_CNT) begin
                            n_status = STAT_FULL;
                        end else if (!r_ipos_set) begin
                            n_ipos = r_count;
                        end
                    end else begin
                        n_status = STAT_NOT_FOUND;
                    end
                end
            end
            ST_SCAN_CHK: begin
                if (r_mode_id && w_id_hit) begin
                    if (r_op == OP_ADD) begin
                        n_status = STAT_DUP;
                    end
                end else if (!r_mode_id && w_later) begin
                    n_ipos = r_idx;
                    n_idx  = r_count;
                end else begin
                    if (r_mode_id && !r_ipos_set && w_later) begin
                        n_ipos     = r_idx;
                        n_ipos_set = 1'b1;
                    end
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_DEL_RD: begin
                if (r_idx + CW'(1) == r_count) begin
                    n_count   = r_count - CW'(1);
                    n_mode_id = 1'b0;
                    n_idx     = '0;
                end
            end
            ST_DEL_WR: n_idx = r_idx + CW'(1);
            ST_INS_WR: n_idx = r_idx - CW'(1);
            ST_INS_PUT: n_count = r_count + CW'(1);
            ST_TICK_CHK: begin
                if (w_expired && (!r_pend_valid || w_slot_free)) begin
                    if (r_pend_valid) begin
                        n_out_valid   = 1'b1;
                        n_o_status    = STAT_OK;
                        n_o_exp_valid = 1'b1;
                        n_o_exp_id    = r_pend_id;
                        n_o_last      = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = w_rd_data.id;
                    n_head       = (r_head == LAST_ADR) ? '0 : r_head + AW'(1);
                    n_count      = r_count - CW'(1);
                    n_nexp       = r_nexp + NEXP_W'(1);
                end
            end
            ST_RESP: begin
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_o_status    = r_status;
                    n_o_exp_valid = r_pend_valid;
                    n_o_exp_id    = r_pend_valid ? r_pend_id : '0;
                    n_o_last      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_mode_id    <= 1'b0;
            r_ipos_set   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_nexp       <= '0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_mode_id    <= n_mode_id;
            r_ipos_set   <= n_ipos_set;
            r_pend_valid <= n_pend_valid;
            r_nexp       <= n_nexp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_id          <= n_id;
        r_time        <= n_time;
        r_idx         <= n_idx;
        r_ipos        <= n_ipos;
        r_pend_id     <= n_pend_id;
        r_status      <= n_status;
        r_o_status    <= n_o_status;
        r_o_exp_valid <= n_o_exp_valid;
        r_o_exp_id    <= n_o_exp_id;
        r_o_last      <= n_o_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_expired_valid = r_o_exp_valid;
    assign o_expired_id    = r_o_exp_id;
    assign o_last          = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("timer count above capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_ADR)
        else $error("head pointer out of range");

    a_nexp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nexp <= NEXP_MAX)
        else $error("tick removed more than the result limit");

    a_expired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_expired_valid |-> o_status == STAT_OK)
        else $error("expired result with error status");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_INS_PUT |-> r_count != FULL_CNT)
        else $error("insert into full queue");

endmodule

>>> dv/tb_sorted_timer_queue.sv
`timescale 1ns / 100ps

module tb_sorted_timer_queue;
    import stq_pkg::*;

    localparam int          MAX_TIMERS  = 64;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          TAIL_CYCLES = 100;

    typedef struct packed {
        logic [1:0]      status;
        logic            expired_valid;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } t_result;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic [1:0]        i_opcode        = OP_TICK;
    logic [ID_W-1:0]   i_conn_id       = '0;
    logic [TIME_W-1:0] i_time_value    = '0;
    logic              i_out_ready     = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [1:0]        o_status;
    logic              o_expired_valid;
    logic [ID_W-1:0]   o_expired_id;
    logic              o_last;

    t_entry      held_timers[$];
    t_result     pending_results[$];
    t_result     want;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned gap_pct      = 0;
    int unsigned stall_pct    = 0;
    logic [TIME_W-1:0] now_sec = '0;

    sorted_timer_queue #(
        .MAX_TIMERS(MAX_TIMERS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_conn_id      (i_conn_id),
        .i_time_value   (i_time_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_expired_valid(o_expired_valid),
        .o_expired_id   (o_expired_id),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, exp);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer, id", 32'(o_expired_id), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_expired_valid !== want.expired_valid)
                    report_mismatch("expired_valid", 32'(o_expired_valid),
                                    32'(want.expired_valid));
                if (o_expired_id !== want.expired_id)
                    report_mismatch("expired_id", 32'(o_expired_id), 32'(want.expired_id));
                if (o_last !== want.last)
                    report_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    function automatic void expect_result(logic [1:0] st, logic ev, logic [ID_W-1:0] id,
                                          logic lst);
        t_result r;
        r.status        = st;
        r.expired_valid = ev;
        r.expired_id    = id;
        r.last          = lst;
        pending_results.push_back(r);
    endfunction

    function automatic int locate_timer(logic [ID_W-1:0] id);
        for (int i = 0; i < held_timers.size(); i++)
            if (held_timers[i].id == id)
                return i;
        return -1;
    endfunction

    // ties go behind existing entries with the same expiry
    function automatic void insert_timer(logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
        int     pos;
        t_entry e;
        pos = 0;
        while (pos < held_timers.size() && held_timers[pos].expiry <= t)
            pos++;
        e.expiry = t;
        e.id     = id;
        held_timers.insert(pos, e);
    endfunction

    function automatic void apply_timer_op(t_opcode op, logic [ID_W-1:0] id,
                                           logic [TIME_W-1:0] t);
        int pos;
        int n;
        pos = locate_timer(id);
        case (op)
            OP_ADD: begin
                if (pos >= 0) begin
                    expect_result(STAT_DUP, 1'b0, '0, 1'b1);
                end else if (held_timers.size() >= MAX_TIMERS) begin
                    expect_result(STAT_FULL, 1'b0, '0, 1'b1);
                end else begin
                    insert_timer(id, t);
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            OP_ADJUST, OP_DELETE: begin
                if (pos < 0) begin
                    expect_result(STAT_NOT_FOUND, 1'b0, '0, 1'b1);
                end else begin
                    held_timers.delete(pos);
                    if (op == OP_ADJUST)
                        insert_timer(id, t);
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            default: begin
                n = 0;
                while (n < held_timers.size() && n < RESULT_LIMIT &&
                       held_timers[n].expiry <= t)
                    n++;
                if (n == 0)
                    expect_result(STAT_OK, 1'b0, '0, 1'b1);
                for (int k = 0; k < n; k++) begin
                    expect_result(STAT_OK, 1'b1, held_timers[0].id, k == n - 1);
                    void'(held_timers.pop_front());
                end
            end
        endcase
    endfunction

    // entered and left just after a rising edge
    task automatic send_timer_op(t_opcode op, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_conn_id    <= id;
        i_time_value <= t;
        do @(posedge i_clk); while (!o_in_ready);
        apply_timer_op(op, id, t);
    endtask

    task automatic set_idling(int unsigned gap, int unsigned stall);
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic test_directed_ops();
        send_timer_op(OP_TICK, 16'h0000, 32'h0000_0000);
        send_timer_op(OP_ADD, 16'h0000, 32'h0000_0000);
        send_timer_op(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF);
        send_timer_op(OP_ADD, 16'h0000, 32'h0000_0010);
        send_timer_op(OP_ADJUST, 16'h1234, 32'h0000_0001);
        send_timer_op(OP_DELETE, 16'h4321, 32'h0000_0000);
        send_timer_op(OP_ADD, 16'h0001, 32'h0000_0005);
        send_timer_op(OP_ADD, 16'h0002, 32'h0000_0005);
        send_timer_op(OP_ADJUST, 16'h0001, 32'h0000_0005);
        send_timer_op(OP_ADD, 16'h0003, 32'h0000_0009);
        send_timer_op(OP_ADJUST, 16'h0003, 32'h0000_0003);
        send_timer_op(OP_ADJUST, 16'h0000, 32'h8000_0000);
        send_timer_op(OP_TICK, 16'hFFFF, 32'h0000_0002);
        send_timer_op(OP_TICK, 16'h0000, 32'h0000_0004);
        send_timer_op(OP_TICK, 16'h0000, 32'h0000_0005);
        send_timer_op(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
        send_timer_op(OP_DELETE, 16'hFFFF, 32'h0000_0000);
        send_timer_op(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
        send_timer_op(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_full_queue();
        logic [TIME_W-1:0] t;
        send_timer_op(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
        for (int i = 0; i < MAX_TIMERS; i++) begin
            t = $urandom_range(1000);
            send_timer_op(OP_ADD, 16'(16'h1000 + i), t);
        end
        send_timer_op(OP_ADD, 16'h2000, 32'h0000_0001);
        send_timer_op(OP_ADD, 16'h1005, 32'h0000_0001);
        send_timer_op(OP_ADJUST, 16'h1000, 32'h0000_0000);
        send_timer_op(OP_TICK, 16'h0000, 32'd500);
        send_timer_op(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_ops(int n_items);
        t_opcode           op;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] t;
        int unsigned       pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (held_timers.size() > 48 && pick < 55)
                pick = 90;
            if (pick < 35)
                op = OP_ADD;
            else if (pick < 55)
                op = OP_ADJUST;
            else if (pick < 75)
                op = OP_DELETE;
            else
                op = OP_TICK;
            if (held_timers.size() > 0 && $urandom_range(99) < 60)
                id = held_timers[$urandom_range(held_timers.size() - 1)].id;
            else
                id = 16'($urandom_range(15));
            if (op == OP_TICK) begin
                now_sec = now_sec + $urandom_range(40);
                t = now_sec;
            end else begin
                t = now_sec + $urandom_range(60);
            end
            // noise: fully random fields
            if ($urandom_range(99) < 12) begin
                op = t_opcode'($urandom_range(3));
                id = 16'($urandom);
                t  = $urandom;
            end
            send_timer_op(op, id, t);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(0, 0);
        test_directed_ops();
        set_idling(0, 83);
        test_full_queue();

        set_idling(0, 0);
        test_random_ops(5);
        set_idling(83, 0);
        test_random_ops(5);
        set_idling(0, 83);
        test_random_ops(5);
        set_idling(7, 7);
        test_random_ops(5);
        send_timer_op(OP_TICK, 16'h0000, 32'hFFFF_FFFF);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            error_count++;

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
